// File: rtl/pressure_temperature_compensation_macros.svh
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// property checked on every rising aclk edge outside reset
`define PTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_CAL_TEMPERATURE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAL_PRESSURE_LOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CAL_PRESSURE_MID  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CAL_PRESSURE_HIGH = 3'd3;

    localparam int RAW_W  = 20;
    localparam int TEMP_W = 16;
    localparam int FINE_W = 21;
    localparam int PRES_W = 32;

    // scaled numerator magnitude, divisor magnitude and quotient widths
    localparam int DIV_N_W = 72;
    localparam int DIV_D_W = 37;
    localparam int DIV_Q_W = 41;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [FINE_W-1:0] fine;
        logic                     den_zero;
        logic                     quo_neg;
        logic                     quo_ovf;
    } div_side_t;

endpackage

// File: rtl/ptc_divider.sv
// ----------------------------------------------------------------------------
// ptc_divider
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module ptc_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [ptc_pkg::DIV_D_W-1:0]   rem_i,
    input  logic [ptc_pkg::DIV_Q_W-1:0]   lo_i,
    input  logic [ptc_pkg::DIV_D_W-1:0]   dmag_i,
    input  ptc_pkg::div_side_t            side_i,
    output logic                          out_vld,
    output logic [ptc_pkg::DIV_Q_W-1:0]   quo_o,
    output ptc_pkg::div_side_t            side_o
);

    localparam int DW = ptc_pkg::DIV_D_W;
    localparam int QW = ptc_pkg::DIV_Q_W;

    logic [DW-1:0]      rem_reg  [QW];
    logic [QW-1:0]      lo_reg   [QW];
    logic [DW-1:0]      dmag_reg [QW];
    ptc_pkg::div_side_t side_reg [QW];
    logic               vld_reg  [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DW-1:0]      rem_src;
        logic [QW-1:0]      lo_src;
        logic [DW-1:0]      dmag_src;
        ptc_pkg::div_side_t side_src;
        logic               vld_src;
        logic [DW:0]        trial;
        logic [DW:0]        diff;
        logic               take;
        logic [DW-1:0]      rem_next;

        if (i == 0) begin : g_first
            assign rem_src  = rem_i;
            assign lo_src   = lo_i;
            assign dmag_src = dmag_i;
            assign side_src = side_i;
            assign vld_src  = in_vld;
        end else begin : g_next
            assign rem_src  = rem_reg[i-1];
            assign lo_src   = lo_reg[i-1];
            assign dmag_src = dmag_reg[i-1];
            assign side_src = side_reg[i-1];
            assign vld_src  = vld_reg[i-1];
        end

        assign trial    = {rem_src, lo_src[QW-1]};
        assign diff     = trial - {1'b0, dmag_src};
        assign take     = (trial >= {1'b0, dmag_src});
        assign rem_next = take ? diff[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                lo_reg[i]   <= {lo_src[QW-2:0], take};
                dmag_reg[i] <= dmag_src;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_vld = vld_reg[QW-1];
    assign quo_o   = lo_reg[QW-1];
    assign side_o  = side_reg[QW-1];

endmodule

// File: rtl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Integer compensation of one raw pressure and temperature conversion.
// Pipeline from input acceptance to m_valid: 11 front stages,
// 41 divider stages, 6 correction stages, output register.
// Throughput: one item per cycle while s_ready is high; the quotient divider is fully pipelined.
// Reset: aresetn synchronous, clears calibration, pipeline valids and skid.
// ----------------------------------------------------------------------------
`include "pressure_temperature_compensation_macros.svh"

module pressure_temperature_compensation (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ptc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ptc_pkg::RAW_W-1:0]          s_raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]          s_raw_temperature,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ptc_pkg::TEMP_W-1:0]  m_temperature_centi,
    output logic signed [ptc_pkg::FINE_W-1:0]  m_fine_temperature,
    output logic [ptc_pkg::PRES_W-1:0]         m_pressure_q24_8,
    output logic                               m_pressure_valid
);

    // calibration
    logic [47:0] cal_t_reg;
    logic [63:0] cal_pl_reg;
    logic [63:0] cal_pm_reg;
    logic [15:0] cal_ph_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_t_reg  <= '0;
            cal_pl_reg <= '0;
            cal_pm_reg <= '0;
            cal_ph_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                ptc_pkg::REG_CAL_TEMPERATURE:   cal_t_reg  <= cfg_wdata[47:0];
                ptc_pkg::REG_CAL_PRESSURE_LOW:  cal_pl_reg <= cfg_wdata;
                ptc_pkg::REG_CAL_PRESSURE_MID:  cal_pm_reg <= cfg_wdata;
                ptc_pkg::REG_CAL_PRESSURE_HIGH: cal_ph_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = cal_t_reg[15:0];
    assign t2 = $signed(cal_t_reg[31:16]);
    assign t3 = $signed(cal_t_reg[47:32]);
    assign p1 = cal_pl_reg[15:0];
    assign p2 = $signed(cal_pl_reg[31:16]);
    assign p3 = $signed(cal_pl_reg[47:32]);
    assign p4 = $signed(cal_pl_reg[63:48]);
    assign p5 = $signed(cal_pm_reg[15:0]);
    assign p6 = $signed(cal_pm_reg[31:16]);
    assign p7 = $signed(cal_pm_reg[47:32]);
    assign p8 = $signed(cal_pm_reg[63:48]);
    assign p9 = $signed(cal_ph_reg);

    // pipeline enable and handshake
    logic en;
    logic skid_vld_reg;
    logic out_vld_reg;

    assign en      = !skid_vld_reg;
    assign s_ready = en;

    // stage valids
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic s6_vld_reg, s7_vld_reg, s8_vld_reg, s9_vld_reg, s10_vld_reg, s11_vld_reg;
    logic p0_vld_reg, p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg, l_vld_reg;
    logic div_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            p0_vld_reg  <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            l_vld_reg   <= 1'b0;
        end else if (en) begin
            s1_vld_reg  <= s_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
            p0_vld_reg  <= div_vld;
            p1_vld_reg  <= p0_vld_reg;
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            p4_vld_reg  <= p3_vld_reg;
            l_vld_reg   <= p4_vld_reg;
        end
    end

    // stage 1: temperature products
    logic signed [17:0] tdiff;
    logic signed [16:0] dt;
    logic signed [33:0] ta_next, dd_next;

    assign tdiff   = $signed({1'b0, s_raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign dt      = $signed({1'b0, s_raw_temperature[19:4]}) - $signed({1'b0, t1});
    assign ta_next = tdiff * t2;
    assign dd_next = dt * dt;

    // stage 2: second-order temperature term
    logic signed [33:0] s1_ta_reg, s2_ta_reg;
    logic [32:0]        s1_dd_reg;
    logic signed [37:0] bm_next, s2_bm_reg;

    assign bm_next = $signed({1'b0, s1_dd_reg[32:12]}) * t3;

    // stage 3: fine temperature
    localparam int FW_C = ptc_pkg::FINE_W;
    logic signed [24:0]        fsum;
    logic signed [FW_C-1:0]    fine_next;

    assign fsum = $signed({{2{s2_ta_reg[33]}}, s2_ta_reg[33:11]})
                + $signed({s2_bm_reg[37], s2_bm_reg[37:14]});

    always_comb begin
        if (fsum < -25'sd1048576) begin
            fine_next = {1'b1, 20'b0};
        end else if (fsum > 25'sd1048575) begin
            fine_next = {1'b0, {20{1'b1}}};
        end else begin
            fine_next = fsum[20:0];
        end
    end

    // stage 4: centi temperature and pressure offset
    logic signed [FW_C-1:0] s3_fine_reg, s4_fine_reg, s5_fine_reg, s6_fine_reg;
    logic signed [FW_C-1:0] s7_fine_reg, s8_fine_reg, s9_fine_reg, s10_fine_reg;
    logic signed [23:0]     f_ext, f5;
    logic signed [15:0]     temp_next;
    logic signed [21:0]     x_next;

    assign f_ext     = {{3{s3_fine_reg[20]}}, s3_fine_reg};
    assign f5        = (f_ext <<< 2) + f_ext + 24'sd128;
    assign temp_next = f5[23:8];
    assign x_next    = $signed({s3_fine_reg[20], s3_fine_reg}) - 22'sd128000;

    // stage 5: products of the offset
    logic signed [21:0] s4_x_reg;
    logic signed [43:0] xx_full;
    logic signed [37:0] xp5_next, xp2_next;

    assign xx_full  = s4_x_reg * s4_x_reg;
    assign xp5_next = s4_x_reg * p5;
    assign xp2_next = s4_x_reg * p2;

    // stage 6: split products of the square
    logic [40:0]        s5_xx_reg;
    logic signed [37:0] s5_xp5_reg, s6_xp5_reg, s7_xp5_reg;
    logic signed [37:0] s5_xp2_reg, s6_xp2_reg, s7_xp2_reg;
    logic signed [40:0] m6l_next, m3l_next, s6_m6l_reg, s6_m3l_reg;
    logic signed [33:0] m6h_next, m3h_next, s6_m6h_reg, s6_m3h_reg;

    assign m6l_next = $signed({1'b0, s5_xx_reg[23:0]}) * p6;
    assign m6h_next = $signed({1'b0, s5_xx_reg[40:24]}) * p6;
    assign m3l_next = $signed({1'b0, s5_xx_reg[23:0]}) * p3;
    assign m3h_next = $signed({1'b0, s5_xx_reg[40:24]}) * p3;

    // stage 7: recombine
    logic signed [57:0] xxp6_next, xxp3_next, s7_xxp6_reg, s7_xxp3_reg;

    assign xxp6_next = $signed({s6_m6h_reg, 24'b0}) + $signed({{17{s6_m6l_reg[40]}}, s6_m6l_reg});
    assign xxp3_next = $signed({s6_m3h_reg, 24'b0}) + $signed({{17{s6_m3l_reg[40]}}, s6_m3l_reg});

    // stage 8: numerator and divisor polynomials
    logic signed [59:0] b_next, s8_b_reg;
    logic signed [51:0] a_next, s8_a_reg;

    assign b_next = $signed({{2{s7_xxp6_reg[57]}}, s7_xxp6_reg})
                  + $signed({{5{s7_xp5_reg[37]}}, s7_xp5_reg, 17'b0})
                  + $signed({{9{p4[15]}}, p4, 35'b0});
    assign a_next = $signed({{2{s7_xxp3_reg[57]}}, s7_xxp3_reg[57:8]})
                  + $signed({{2{s7_xp2_reg[37]}}, s7_xp2_reg, 12'b0});

    // stage 9: divisor partial products, numerator
    logic signed [52:0] v;
    logic signed [43:0] ph_next, pl_next, s9_ph_reg, s9_pl_reg;
    logic [20:0]        pd;
    logic signed [60:0] num_next, s9_num_reg;
    logic [19:0]        s1_adcp_reg, s2_adcp_reg, s3_adcp_reg, s4_adcp_reg;
    logic [19:0]        s5_adcp_reg, s6_adcp_reg, s7_adcp_reg, s8_adcp_reg;

    assign v        = $signed({s8_a_reg[51], s8_a_reg}) + 53'sh800000000000;
    assign ph_next  = $signed(v[52:26]) * $signed({1'b0, p1});
    assign pl_next  = $signed({1'b0, v[25:0]}) * $signed({1'b0, p1});
    assign pd       = 21'd1048576 - {1'b0, s8_adcp_reg};
    assign num_next = $signed({9'b0, pd, 31'b0}) - $signed({s8_b_reg[59], s8_b_reg});

    // stage 10: divisor, scaled numerator
    logic signed [70:0] dsum;
    logic signed [37:0] den_next, s10_den_reg;
    logic signed [72:0] n3125_next, s10_n_reg;

    assign dsum       = $signed({s9_ph_reg[43], s9_ph_reg, 26'b0})
                      + $signed({{27{s9_pl_reg[43]}}, s9_pl_reg});
    assign den_next   = dsum[70:33];
    assign n3125_next = s9_num_reg * 13'sd3125;

    // stage 11: magnitudes and overflow check
    logic [72:0]                      n_abs;
    logic [37:0]                      d_abs;
    logic [ptc_pkg::DIV_N_W-1:0]      nmag;
    logic [ptc_pkg::DIV_D_W-1:0]      dmag_next, rem_init, s11_dmag_reg, s11_rem_reg;
    logic [ptc_pkg::DIV_Q_W-1:0]      s11_lo_reg;
    ptc_pkg::div_side_t               side_next, s11_side_reg;

    assign n_abs     = s10_n_reg[72] ? 73'(-s10_n_reg) : s10_n_reg;
    assign d_abs     = s10_den_reg[37] ? 38'(-s10_den_reg) : s10_den_reg;
    assign nmag      = n_abs[71:0];
    assign dmag_next = d_abs[36:0];
    assign rem_init  = {6'b0, nmag[71:41]};

    logic signed [15:0] s4_temp_reg, s5_temp_reg, s6_temp_reg, s7_temp_reg;
    logic signed [15:0] s8_temp_reg, s9_temp_reg, s10_temp_reg;

    always_comb begin
        side_next.temp     = s10_temp_reg;
        side_next.fine     = s10_fine_reg;
        side_next.den_zero = (s10_den_reg == 38'sd0);
        side_next.quo_neg  = s10_n_reg[72] ^ s10_den_reg[37];
        side_next.quo_ovf  = (rem_init >= dmag_next);
    end

    // front stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ta_reg    <= ta_next;
            s1_dd_reg    <= dd_next[32:0];
            s1_adcp_reg  <= s_raw_pressure;

            s2_ta_reg    <= s1_ta_reg;
            s2_bm_reg    <= bm_next;
            s2_adcp_reg  <= s1_adcp_reg;

            s3_fine_reg  <= fine_next;
            s3_adcp_reg  <= s2_adcp_reg;

            s4_x_reg     <= x_next;
            s4_temp_reg  <= temp_next;
            s4_fine_reg  <= s3_fine_reg;
            s4_adcp_reg  <= s3_adcp_reg;

            s5_xx_reg    <= xx_full[40:0];
            s5_xp5_reg   <= xp5_next;
            s5_xp2_reg   <= xp2_next;
            s5_temp_reg  <= s4_temp_reg;
            s5_fine_reg  <= s4_fine_reg;
            s5_adcp_reg  <= s4_adcp_reg;

            s6_m6l_reg   <= m6l_next;
            s6_m6h_reg   <= m6h_next;
            s6_m3l_reg   <= m3l_next;
            s6_m3h_reg   <= m3h_next;
            s6_xp5_reg   <= s5_xp5_reg;
            s6_xp2_reg   <= s5_xp2_reg;
            s6_temp_reg  <= s5_temp_reg;
            s6_fine_reg  <= s5_fine_reg;
            s6_adcp_reg  <= s5_adcp_reg;

            s7_xxp6_reg  <= xxp6_next;
            s7_xxp3_reg  <= xxp3_next;
            s7_xp5_reg   <= s6_xp5_reg;
            s7_xp2_reg   <= s6_xp2_reg;
            s7_temp_reg  <= s6_temp_reg;
            s7_fine_reg  <= s6_fine_reg;
            s7_adcp_reg  <= s6_adcp_reg;

            s8_b_reg     <= b_next;
            s8_a_reg     <= a_next;
            s8_temp_reg  <= s7_temp_reg;
            s8_fine_reg  <= s7_fine_reg;
            s8_adcp_reg  <= s7_adcp_reg;

            s9_ph_reg    <= ph_next;
            s9_pl_reg    <= pl_next;
            s9_num_reg   <= num_next;
            s9_temp_reg  <= s8_temp_reg;
            s9_fine_reg  <= s8_fine_reg;

            s10_den_reg  <= den_next;
            s10_n_reg    <= n3125_next;
            s10_temp_reg <= s9_temp_reg;
            s10_fine_reg <= s9_fine_reg;

            s11_rem_reg  <= rem_init;
            s11_lo_reg   <= nmag[40:0];
            s11_dmag_reg <= dmag_next;
            s11_side_reg <= side_next;
        end
    end

    // quotient divider
    logic [ptc_pkg::DIV_Q_W-1:0] div_quo;
    ptc_pkg::div_side_t          div_side;

    ptc_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s11_vld_reg),
        .rem_i   (s11_rem_reg),
        .lo_i    (s11_lo_reg),
        .dmag_i  (s11_dmag_reg),
        .side_i  (s11_side_reg),
        .out_vld (div_vld),
        .quo_o   (div_quo),
        .side_o  (div_side)
    );

    // p0: saturate and sign the quotient
    logic [40:0]        pm;
    logic signed [41:0] p_next;

    assign pm     = (div_side.quo_ovf || (div_quo > {1'b1, 40'b0})) ? {1'b1, 40'b0} : div_quo;
    assign p_next = div_side.quo_neg ? $signed(-{1'b0, pm}) : $signed({1'b0, pm});

    // p1: square and p8 partial products
    logic signed [41:0] p0_p_reg, p1_p_reg, p2_p_reg, p3_p_reg;
    logic signed [57:0] ss_full;
    logic signed [36:0] ph8_next, p1_ph8_reg;
    logic signed [37:0] pl8_next, p1_pl8_reg;

    assign ss_full  = $signed(p0_p_reg[41:13]) * $signed(p0_p_reg[41:13]);
    assign ph8_next = $signed(p0_p_reg[41:21]) * p8;
    assign pl8_next = $signed({1'b0, p0_p_reg[20:0]}) * p8;

    // p2: p9 partial products, p8 correction
    logic [54:0]        p1_ss_reg;
    logic signed [44:0] m9h_next, p2_m9h_reg;
    logic signed [43:0] m9l_next, p2_m9l_reg;
    logic signed [58:0] c2sum;
    logic signed [39:0] p2_c2_reg, p3_c2_reg;

    assign m9h_next = $signed({1'b0, p1_ss_reg[54:27]}) * p9;
    assign m9l_next = $signed({1'b0, p1_ss_reg[26:0]}) * p9;
    assign c2sum    = $signed({p1_ph8_reg[36], p1_ph8_reg, 21'b0})
                    + $signed({{21{p1_pl8_reg[37]}}, p1_pl8_reg});

    // p3: p9 correction
    logic signed [72:0] c1sum;
    logic signed [47:0] p3_c1_reg;

    assign c1sum = $signed({p2_m9h_reg[44], p2_m9h_reg, 27'b0})
                 + $signed({{29{p2_m9l_reg[43]}}, p2_m9l_reg});

    // p4: corrected sum
    logic signed [49:0] psum_next, p4_psum_reg;

    assign psum_next = $signed({{8{p3_p_reg[41]}}, p3_p_reg})
                     + $signed({{2{p3_c1_reg[47]}}, p3_c1_reg})
                     + $signed({{10{p3_c2_reg[39]}}, p3_c2_reg});

    // p5: offset, clamp and flag
    logic signed [42:0] pf;
    logic               pos;
    logic               pval_next;
    logic [31:0]        pout_next;

    ptc_pkg::div_side_t p0_side_reg, p1_side_reg, p2_side_reg, p3_side_reg, p4_side_reg;

    assign pf        = $signed({p4_psum_reg[49], p4_psum_reg[49:8]})
                     + $signed({{23{p7[15]}}, p7, 4'b0});
    assign pos       = !pf[42] && (pf != 43'sd0);
    assign pval_next = pos && !p4_side_reg.den_zero;
    assign pout_next = !pval_next ? 32'd0 : ((|pf[41:32]) ? {32{1'b1}} : pf[31:0]);

    logic signed [15:0]     l_temp_reg;
    logic signed [FW_C-1:0] l_fine_reg;
    logic [31:0]            l_pout_reg;
    logic                   l_pval_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_p_reg    <= p_next;
            p0_side_reg <= div_side;

            p1_ss_reg   <= ss_full[54:0];
            p1_ph8_reg  <= ph8_next;
            p1_pl8_reg  <= pl8_next;
            p1_p_reg    <= p0_p_reg;
            p1_side_reg <= p0_side_reg;

            p2_m9h_reg  <= m9h_next;
            p2_m9l_reg  <= m9l_next;
            p2_c2_reg   <= c2sum[58:19];
            p2_p_reg    <= p1_p_reg;
            p2_side_reg <= p1_side_reg;

            p3_c1_reg   <= c1sum[72:25];
            p3_c2_reg   <= p2_c2_reg;
            p3_p_reg    <= p2_p_reg;
            p3_side_reg <= p2_side_reg;

            p4_psum_reg <= psum_next;
            p4_side_reg <= p3_side_reg;

            l_temp_reg  <= p4_side_reg.temp;
            l_fine_reg  <= p4_side_reg.fine;
            l_pout_reg  <= pout_next;
            l_pval_reg  <= pval_next;
        end
    end

    // output register and skid
    logic                   load_out;
    logic signed [15:0]     out_temp_reg, skid_temp_reg;
    logic signed [FW_C-1:0] out_fine_reg, skid_fine_reg;
    logic [31:0]            out_pout_reg, skid_pout_reg;
    logic                   out_pval_reg, skid_pval_reg;

    assign load_out = !out_vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (load_out) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg  <= l_vld_reg;
            end
        end else if (en) begin
            skid_vld_reg <= l_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (skid_vld_reg) begin
                out_temp_reg <= skid_temp_reg;
                out_fine_reg <= skid_fine_reg;
                out_pout_reg <= skid_pout_reg;
                out_pval_reg <= skid_pval_reg;
            end else begin
                out_temp_reg <= l_temp_reg;
                out_fine_reg <= l_fine_reg;
                out_pout_reg <= l_pout_reg;
                out_pval_reg <= l_pval_reg;
            end
        end else if (en) begin
            skid_temp_reg <= l_temp_reg;
            skid_fine_reg <= l_fine_reg;
            skid_pout_reg <= l_pout_reg;
            skid_pval_reg <= l_pval_reg;
        end
    end

    assign m_valid             = out_vld_reg;
    assign m_temperature_centi = out_temp_reg;
    assign m_fine_temperature  = out_fine_reg;
    assign m_pressure_q24_8    = out_pout_reg;
    assign m_pressure_valid    = out_pval_reg;

    // checks
    `PTC_ASSERT(a_skid_needs_out, skid_vld_reg |-> out_vld_reg, "skid holds item without output")
    `PTC_ASSERT(a_zero_when_invalid, (m_valid && !m_pressure_valid) |-> (m_pressure_q24_8 == 32'd0), "invalid pressure not zero")
    `PTC_ASSERT(a_nonzero_when_valid, (m_valid && m_pressure_valid) |-> (m_pressure_q24_8 != 32'd0), "valid pressure is zero")
    `PTC_ASSERT_NEXT(a_stall_fills_skid, out_vld_reg && !m_ready && l_vld_reg && en, skid_vld_reg, "stalled item lost")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pressure/temperature compensation block.
// Walks a short table of directed conversions, then runs about a thousand
// random conversions under several calibration sets, loaded while the block
// is idle. Every result is checked field by field against an exact-integer
// model or a typed expectation, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [ptc_pkg::TEMP_W-1:0] temp;
        logic [ptc_pkg::FINE_W-1:0] fine;
        logic [ptc_pkg::PRES_W-1:0] pres;
        logic                       pres_ok;
    } comp_result_t;

    typedef struct {
        logic [ptc_pkg::RAW_W-1:0] raw_p;
        logic [ptc_pkg::RAW_W-1:0] raw_t;
        bit                        typed;
        comp_result_t              want;
    } conv_row_t;

    localparam int  PERIOD      = 20;
    localparam int  DRAIN_WAIT  = 80;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  HOLD_CYCLES = 300;
    localparam int  PHASES      = 9;
    localparam int  PHASE_ITEMS = 110;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [ptc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ptc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [ptc_pkg::RAW_W-1:0]       s_raw_pressure = '0;
    logic [ptc_pkg::RAW_W-1:0]       s_raw_temperature = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic signed [ptc_pkg::TEMP_W-1:0] m_temperature_centi;
    logic signed [ptc_pkg::FINE_W-1:0] m_fine_temperature;
    logic [ptc_pkg::PRES_W-1:0]      m_pressure_q24_8;
    logic                            m_pressure_valid;

    logic [47:0] cal_temp  = '0;
    logic [63:0] cal_plow  = '0;
    logic [63:0] cal_pmid  = '0;
    logic [15:0] cal_phigh = '0;

    comp_result_t pending_q[$];
    int  errors = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  valid_pressures = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;

    pressure_temperature_compensation DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_raw_pressure(s_raw_pressure), .s_raw_temperature(s_raw_temperature),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_temperature_centi(m_temperature_centi),
        .m_fine_temperature(m_fine_temperature),
        .m_pressure_q24_8(m_pressure_q24_8),
        .m_pressure_valid(m_pressure_valid)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic wide_t clip(wide_t v, wide_t lo, wide_t hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic comp_result_t compensate(logic [ptc_pkg::RAW_W-1:0] rp,
                                                logic [ptc_pkg::RAW_W-1:0] rt);
        wide_t adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        wide_t a, b, dt, fine, temp, x, num, den, q, r, p, s, c1, c2;
        comp_result_t res;
        adc_p = wide_t'(rp);
        adc_t = wide_t'(rt);
        t1 = wide_t'(cal_temp[15:0]);
        t2 = wide_t'($signed(cal_temp[31:16]));
        t3 = wide_t'($signed(cal_temp[47:32]));
        p1 = wide_t'(cal_plow[15:0]);
        p2 = wide_t'($signed(cal_plow[31:16]));
        p3 = wide_t'($signed(cal_plow[47:32]));
        p4 = wide_t'($signed(cal_plow[63:48]));
        p5 = wide_t'($signed(cal_pmid[15:0]));
        p6 = wide_t'($signed(cal_pmid[31:16]));
        p7 = wide_t'($signed(cal_pmid[47:32]));
        p8 = wide_t'($signed(cal_pmid[63:48]));
        p9 = wide_t'($signed(cal_phigh));
        a = (((adc_t >>> 3) - 2 * t1) * t2) >>> 11;
        dt = (adc_t >>> 4) - t1;
        b = (((dt * dt) >>> 12) * t3) >>> 14;
        fine = clip(a + b, -1048576, 1048575);
        temp = clip((fine * 5 + 128) >>> 8, -32768, 32767);
        x = fine - 128000;
        b = x * x * p6 + x * p5 * 131072 + p4 * (wide_t'(1) <<< 35);
        a = ((x * x * p3) >>> 8) + x * p2 * 4096;
        den = (((wide_t'(1) <<< 47) + a) * p1) >>> 33;
        res.temp = temp[ptc_pkg::TEMP_W-1:0];
        res.fine = fine[ptc_pkg::FINE_W-1:0];
        res.pres = '0;
        res.pres_ok = 1'b0;
        if (den != 0) begin
            num = (1048576 - adc_p) * (wide_t'(1) <<< 31) - b;
            q = num / den;
            r = num % den;
            if (q > 351843720)
                p = wide_t'(1) <<< 40;
            else if (q < -351843720)
                p = -(wide_t'(1) <<< 40);
            else
                p = clip(q * 3125 + (r * 3125) / den, -(wide_t'(1) <<< 40),
                         wide_t'(1) <<< 40);
            s = p >>> 13;
            c1 = (s * s * p9) >>> 25;
            c2 = (p8 * p) >>> 19;
            p = ((p + c1 + c2) >>> 8) + p7 * 16;
            if (p > 0) begin
                res.pres_ok = 1'b1;
                res.pres = p > 128'sh0FFFF_FFFF ? 32'hFFFF_FFFF : p[31:0];
            end
        end
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got,
                 want, results_seen);
    endtask

    always @(posedge aclk) begin
        comp_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                w = pending_q.pop_front();
                if (m_temperature_centi !== w.temp)
                    report("temperature", m_temperature_centi, $signed(w.temp));
                if (m_fine_temperature !== w.fine)
                    report("fine temperature", m_fine_temperature, $signed(w.fine));
                if (m_pressure_q24_8 !== w.pres)
                    report("pressure", m_pressure_q24_8, w.pres);
                if (m_pressure_valid !== w.pres_ok)
                    report("pressure valid", m_pressure_valid, w.pres_ok);
                if (w.pres_ok)
                    valid_pressures++;
            end
            results_seen++;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (quiet) begin
                m_ready = 1'b1;
            end else if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready = 1'b1;
                hold_req = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready = 1'b1;
                repeat ($urandom_range(20, 80)) @(negedge aclk);
            end else begin
                m_ready = 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
            end
        end
    end

    task automatic write_cal(logic [ptc_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            ptc_pkg::REG_CAL_TEMPERATURE:   cal_temp = data[47:0];
            ptc_pkg::REG_CAL_PRESSURE_LOW:  cal_plow = data;
            ptc_pkg::REG_CAL_PRESSURE_MID:  cal_pmid = data;
            ptc_pkg::REG_CAL_PRESSURE_HIGH: cal_phigh = data[15:0];
            default: ;
        endcase
    endtask

    task automatic load_cal(logic [63:0] ct, logic [63:0] pl, logic [63:0] pm,
                            logic [63:0] ph);
        write_cal(ptc_pkg::REG_CAL_TEMPERATURE, ct);
        write_cal(ptc_pkg::REG_CAL_PRESSURE_LOW, pl);
        write_cal(ptc_pkg::REG_CAL_PRESSURE_MID, pm);
        write_cal(ptc_pkg::REG_CAL_PRESSURE_HIGH, ph);
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance or after a random idle gap
    task automatic send(logic [ptc_pkg::RAW_W-1:0] rp, logic [ptc_pkg::RAW_W-1:0] rt,
                        bit typed, comp_result_t want);
        s_valid = 1'b1;
        s_raw_pressure = rp;
        s_raw_temperature = rt;
        do @(posedge aclk); while (!s_ready);
        pending_q.push_back(typed ? want : compensate(rp, rt));
        items_sent++;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
    endtask

    task automatic send_random(int n);
        logic [ptc_pkg::RAW_W-1:0] rp, rt;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                rp = 20'($urandom);
                rt = 20'($urandom);
            end else begin
                rp = 20'($urandom_range(250000, 650000));
                rt = 20'($urandom_range(420000, 620000));
            end
            send(rp, rt, 1'b0, '0);
        end
        s_valid = 1'b0;
    endtask

    conv_row_t rows[$];

    task automatic add_row(logic [ptc_pkg::RAW_W-1:0] rp, logic [ptc_pkg::RAW_W-1:0] rt,
                           bit typed);
        conv_row_t row;
        row.raw_p = rp;
        row.raw_t = rt;
        row.typed = typed;
        row.want = '0;
        rows.push_back(row);
    endtask

    localparam logic [63:0] TYP_T  = {16'h0, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PL = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PM = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [63:0] TYP_PH = 64'd6000;

    initial begin
        logic [63:0] ct, pl, pm, ph;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // calibration still at reset: no divisor, temperature terms all zero
        add_row(20'h00000, 20'h00000, 1'b1);
        add_row(20'hFFFFF, 20'hFFFFF, 1'b1);
        add_row(20'h00000, 20'hFFFFF, 1'b1);
        add_row(20'hFFFFF, 20'h00000, 1'b1);
        add_row(20'h80000, 20'h80000, 1'b1);
        foreach (rows[i]) send(rows[i].raw_p, rows[i].raw_t, 1'b1, rows[i].want);
        s_valid = 1'b0;
        drain();

        rows.delete();
        load_cal(TYP_T, TYP_PL, TYP_PM, TYP_PH);
        write_cal(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(3'd7, 64'h0);
        add_row(20'd415148, 20'd519888, 1'b0);
        add_row(20'd0, 20'd519888, 1'b0);
        add_row(20'hFFFFF, 20'd519888, 1'b0);
        add_row(20'd415148, 20'd0, 1'b0);
        add_row(20'd415148, 20'hFFFFF, 1'b0);
        add_row(20'hFFFFF, 20'hFFFFF, 1'b0);
        add_row(20'd0, 20'd0, 1'b0);
        add_row(20'hAAAAA, 20'h55555, 1'b0);
        add_row(20'h55555, 20'hAAAAA, 1'b0);
        add_row(20'd1048575, 20'd400000, 1'b0);
        foreach (rows[i]) send(rows[i].raw_p, rows[i].raw_t, 1'b0, rows[i].want);
        s_valid = 1'b0;
        drain();

        // zero divisor with the rest of the calibration in place
        write_cal(ptc_pkg::REG_CAL_PRESSURE_LOW, {TYP_PL[63:16], 16'd0});
        send(20'd415148, 20'd519888, 1'b0, '0);
        send(20'hFFFFF, 20'hFFFFF, 1'b0, '0);
        s_valid = 1'b0;
        drain();

        for (int ph_i = 0; ph_i < PHASES; ph_i++) begin
            case (ph_i)
                0: begin ct = TYP_T; pl = TYP_PL; pm = TYP_PM; ph = TYP_PH; end
                1: begin ct = '1; pl = '1; pm = '1; ph = '1; end
                2: begin
                    ct = {4{16'h8000}}; pl = {4{16'h8000}};
                    pm = {4{16'h8000}}; ph = {4{16'h8000}};
                end
                3: begin
                    ct = {4{16'h7FFF}}; pl = {4{16'h7FFF}};
                    pm = {4{16'h7FFF}}; ph = {4{16'h7FFF}};
                end
                4, 5: begin
                    ct = {$urandom, $urandom}; pl = {$urandom, $urandom};
                    pm = {$urandom, $urandom}; ph = {$urandom, $urandom};
                end
                default: begin
                    ct = TYP_T ^ {$urandom_range(0, 255), $urandom_range(0, 1023)};
                    pl = TYP_PL ^ {$urandom_range(0, 255), $urandom_range(0, 1023)};
                    pm = TYP_PM ^ {$urandom_range(0, 255), $urandom_range(0, 1023)};
                    ph = {32'd0, $urandom};
                end
            endcase
            load_cal(ct, pl, pm, ph);
            if (ph_i == 2) begin
                hold_req = 1'b1;
                send_random(PHASE_ITEMS);
            end else if (ph_i == PHASES - 1) begin
                quiet = 1'b1;
                send_random(PHASE_ITEMS);
            end else begin
                send_random(PHASE_ITEMS / 2);
                while (pending_q.size() != 0) @(negedge aclk);
                send_random(PHASE_ITEMS / 2);
            end
            drain();
        end

        $display("%0d conversions sent, %0d results checked, %0d with valid pressure",
                 items_sent, results_seen, valid_pressures);
        $display("covered reset, typical, extreme and random calibration sets");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
